[hdl/sliding_window_receiver_top_macros.svh]
// Assertion macros shared by the checker of the sliding window receiver.
`ifndef SLIDING_WINDOW_RECEIVER_TOP_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define SWR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window receiver check failed");

// Next-cycle implication, off during reset.
`define SWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window receiver check failed");

// What must hold in the cycle after reset is seen.
`define SWR_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("sliding window receiver reset check failed");

`endif

[hdl/swr_pkg.sv]
// Package: types and constants shared by the sliding window receiver modules.
`default_nettype none

package swr_pkg;

  localparam int SEQ_W = 32;
  localparam int CFG_W = 9;

  // Window size after reset.
  localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd200;

  // Input queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_num;
    logic             is_finish;
  } swr_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic      valid;
    swr_item_t item;
  } swr_q_t;

  // Back end control toward the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } swr_bk_t;

endpackage

`default_nettype wire

[hdl/swr_front.sv]
// Front end: accepts packet transactions into a short queue for the back end.
`default_nettype none

module swr_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [swr_pkg::SEQ_W-1:0] seq_num,
  input  wire logic                     is_finish,
  output swr_pkg::swr_q_t               q,
  input  wire swr_pkg::swr_bk_t         bk
);
  import swr_pkg::*;

  swr_item_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr;
  logic [Q_PTR_W-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0]    count;
  logic                  push;
  logic                  pop;

  // No transaction taken while the back end sweeps its bit store.
  assign in_ready = !bk.clearing && (count != Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = bk.pop && (count != '0);

  assign q.valid = (count != '0);
  assign q.item  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{seq_num: seq_num, is_finish: is_finish};
    end
  end

endmodule

`default_nettype wire

[hdl/swr_back.sv]
// Back end: window check, received-bit store, window slide and ack register.
`default_nettype none

module swr_back #(
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire swr_pkg::swr_q_t           q,
  output swr_pkg::swr_bk_t               bk,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [swr_pkg::CFG_W-1:0] window_size,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [swr_pkg::SEQ_W-1:0]      cumulative_ack,
  output logic [swr_pkg::SEQ_W-1:0]      selective_ack,
  output logic                           store_payload,
  output logic                           finished
);
  import swr_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int EW_W  = IDX_W + 1;
  localparam logic [EW_W-1:0]  DEPTH_W  = EW_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MARK   = 5'b00100,
    S_SLIDE  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   head;
  logic [SEQ_W-1:0]   next_expected;
  logic [SEQ_W-1:0]   last_seq;
  logic               last_known;
  logic [CFG_W-1:0]   win_size;

  logic [IDX_W-1:0]   cur_slot;
  logic               cur_zero;
  logic [SEQ_W-1:0]   sel_ack;
  logic               store_flag;

  // Received-bit store
  logic               mem [WINDOW_DEPTH];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic               mem_wd;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_ra;
  logic               rd_data;

  logic [EW_W-1:0]    eff_win;
  logic [SEQ_W-1:0]   offset;
  logic               in_win;
  logic [EW_W-1:0]    slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   head_inc;
  logic               load_out;

  assign cfg_ready   = 1'b1;

  // Window limit and in-window test for the queue head
  assign eff_win  = (32'(win_size) > 32'(WINDOW_DEPTH)) ? DEPTH_W : EW_W'(win_size);
  assign offset   = q.item.seq_num - next_expected;
  assign in_win   = offset < 32'(eff_win);
  assign slot_sum = {1'b0, head} + offset[IDX_W:0];
  assign slot     = (slot_sum >= DEPTH_W) ? IDX_W'(slot_sum - DEPTH_W)
                                          : slot_sum[IDX_W-1:0];
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign load_out = !out_valid || out_ready;

  // Sequencer: memory port control and next state
  always_comb begin
    state_next  = state;
    bk.pop      = 1'b0;
    bk.clearing = (state == S_CLEAR);
    mem_we      = 1'b0;
    mem_wa      = head;
    mem_wd      = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = slot;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.valid) begin
          bk.pop = 1'b1;
          if (in_win) begin
            mem_re     = 1'b1;
            state_next = S_MARK;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_MARK: begin
        if (cur_zero) begin
          // head slot is filled: it slides out at once, so it is never set
          mem_re     = 1'b1;
          mem_ra     = head_inc;
          state_next = S_SLIDE;
        end else begin
          mem_we     = 1'b1;
          mem_wa     = cur_slot;
          mem_wd     = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_SLIDE: begin
        if (rd_data) begin
          mem_we = 1'b1;
          mem_re = 1'b1;
          mem_ra = head_inc;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Bit store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      head          <= '0;
      next_expected <= '0;
      last_seq      <= '0;
      last_known    <= 1'b0;
      win_size      <= WINDOW_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        win_size <= window_size;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (q.valid && q.item.is_finish) begin
            last_seq   <= q.item.seq_num;
            last_known <= 1'b1;
          end
        end
        S_MARK: begin
          if (cur_zero) begin
            head          <= head_inc;
            next_expected <= next_expected + 1'b1;
          end
        end
        S_SLIDE: begin
          if (rd_data) begin
            head          <= head_inc;
            next_expected <= next_expected + 1'b1;
          end
        end
        default: begin
        end
      endcase
      // Result register
      if ((state == S_RESULT) && load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-transaction payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && q.valid) begin
      cur_slot   <= slot;
      cur_zero   <= (offset == '0);
      sel_ack    <= in_win ? q.item.seq_num : next_expected;
      store_flag <= 1'b0;
    end
    if (state == S_MARK) begin
      store_flag <= !rd_data;
    end
    if ((state == S_RESULT) && load_out) begin
      cumulative_ack <= next_expected;
      selective_ack  <= sel_ack;
      store_payload  <= store_flag;
      finished       <= last_known && (next_expected == last_seq + 1'b1);
    end
  end

endmodule

`default_nettype wire

[hdl/sliding_window_receiver_top.sv]
// Top level of the selective-repeat sliding window receiver.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid/in_ready   | seq_num, is_finish
//  output   | out_valid/out_ready | cumulative_ack, selective_ack, store_payload, finished
//  config   | cfg_valid/cfg_ready | window_size
//
// A packet outside the window goes from idle straight to the result state;
// one inside reads its slot, then marks it or slides the window slot by
// slot over the received-bit memory before the result state. After reset
// a clearing pass sweeps that memory with in_ready low; cfg_ready is
// always high. A two-entry queue keeps taking packets while a result waits.
`default_nettype none

module sliding_window_receiver_top #(
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [swr_pkg::SEQ_W-1:0] seq_num,
  input  wire logic                      is_finish,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [swr_pkg::SEQ_W-1:0]      cumulative_ack,
  output logic [swr_pkg::SEQ_W-1:0]      selective_ack,
  output logic                           store_payload,
  output logic                           finished,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [swr_pkg::CFG_W-1:0] window_size
);
  import swr_pkg::*;

  swr_q_t  q;
  swr_bk_t bk;

  swr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .seq_num   (seq_num),
    .is_finish (is_finish),
    .q         (q),
    .bk        (bk)
  );

  swr_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q              (q),
    .bk             (bk),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cumulative_ack (cumulative_ack),
    .selective_ack  (selective_ack),
    .store_payload  (store_payload),
    .finished       (finished)
  );

endmodule

`default_nettype wire

[hdl/swr_checker.sv]
// Port-level checker for the sliding window receiver, bound to the top level.
`default_nettype none

`include "sliding_window_receiver_top_macros.svh"

module swr_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [swr_pkg::SEQ_W-1:0] cumulative_ack,
  input wire logic [swr_pkg::SEQ_W-1:0] selective_ack,
  input wire logic                      store_payload,
  input wire logic                      finished
);

  // Reset empties the result register and starts the clearing pass.
  `SWR_ASSERT_RESET(a_reset_quiet, !in_ready && !out_valid)

  // A newly stored packet never equals the cumulative ack: either the window
  // slid past it or it sits ahead of the gap.
  `SWR_ASSERT_SAME(a_store_ahead, out_valid && store_payload, selective_ack != cumulative_ack)

  // A stalled result holds.
  `SWR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cumulative_ack) && $stable(selective_ack) && $stable(store_payload) && $stable(finished))

endmodule

bind sliding_window_receiver_top swr_checker u_swr_checker (.*);

`default_nettype wire

[test/swr_checker.sv]
// Checker for the sliding window receiver: tracks the window, predicts each ack and compares.
module swr_scoreboard #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [swr_pkg::SEQ_W-1:0] seq_num,
  input  logic                      is_finish,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [swr_pkg::SEQ_W-1:0] cumulative_ack,
  input  logic [swr_pkg::SEQ_W-1:0] selective_ack,
  input  logic                      store_payload,
  input  logic                      finished,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [swr_pkg::CFG_W-1:0] window_size,
  output int                        pending,
  output int                        errors
);
  import swr_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0] cum_ack;
    logic [SEQ_W-1:0] sel_ack;
    logic             store;
    logic             done;
  } ack_t;

  // Acks owed by the block, oldest first
  ack_t acks_due[$];

  // Shadow of the receive window
  bit               slot_taken [WINDOW_DEPTH];
  int unsigned      head_slot;
  logic [SEQ_W-1:0] next_seq;
  logic [SEQ_W-1:0] final_seq;
  logic             final_known;
  logic [CFG_W-1:0] win_size;
  int               mismatches;

  ack_t      got_ack;
  ack_t      want_ack;
  swr_item_t pkt;

  // Apply one packet to the window and return the ack it should draw
  function automatic ack_t accept_packet(swr_item_t p);
    ack_t             a;
    logic [SEQ_W-1:0] offset;
    int unsigned      span;
    int unsigned      slot;
    span = (32'(win_size) > WINDOW_DEPTH) ? WINDOW_DEPTH : 32'(win_size);
    offset = p.seq_num - next_seq;
    if (p.is_finish) begin
      final_seq = p.seq_num;
      final_known = 1'b1;
    end
    a.store = 1'b0;
    if (offset < span) begin
      slot = (head_slot + offset) % WINDOW_DEPTH;
      if (!slot_taken[slot]) begin
        slot_taken[slot] = 1'b1;
        a.store = 1'b1;
      end
      a.sel_ack = p.seq_num;
      // slide past every leading received slot
      for (int n = 0; n < WINDOW_DEPTH && slot_taken[head_slot]; n++) begin
        slot_taken[head_slot] = 1'b0;
        head_slot = (head_slot + 1) % WINDOW_DEPTH;
        next_seq = next_seq + 32'd1;
      end
    end else begin
      a.sel_ack = next_seq;
    end
    a.cum_ack = next_seq;
    a.done = final_known && (next_seq == final_seq + 32'd1);
    return a;
  endfunction

  task automatic log_mismatch(string what, ack_t want, ack_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("swr_chk: %s at %0t: exp cum=%h sel=%h store=%b fin=%b", what, $realtime,
               want.cum_ack, want.sel_ack, want.store, want.done);
      $display("swr_chk:   act cum=%h sel=%h store=%b fin=%b",
               got.cum_ack, got.sel_ack, got.store, got.done);
    end
  endtask

  // Watch the three channels; pop before push so an ack never matches its own packet
  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      head_slot = 0;
      next_seq = '0;
      final_seq = '0;
      final_known = 1'b0;
      win_size = WINDOW_RESET;
      mismatches = 0;
      acks_due.delete();
      pending <= 0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) win_size = window_size;
      if (out_valid && out_ready) begin
        got_ack.cum_ack = cumulative_ack;
        got_ack.sel_ack = selective_ack;
        got_ack.store = store_payload;
        got_ack.done = finished;
        if (acks_due.size() == 0) begin
          want_ack = '0;
          log_mismatch("unexpected ack", want_ack, got_ack);
        end else begin
          want_ack = acks_due[0];
          acks_due.delete(0);
          if (got_ack.cum_ack !== want_ack.cum_ack || got_ack.sel_ack !== want_ack.sel_ack ||
              got_ack.store !== want_ack.store || got_ack.done !== want_ack.done)
            log_mismatch("ack mismatch", want_ack, got_ack);
        end
      end
      if (in_valid && in_ready) begin
        pkt.seq_num = seq_num;
        pkt.is_finish = is_finish;
        acks_due.insert(acks_due.size(), accept_packet(pkt));
      end
      pending <= acks_due.size();
      errors <= mismatches;
    end
  end

endmodule

[test/tb_top.sv]
// Testbench top for the sliding window receiver: packet stimulus, ack back-pressure, verdict.
module tb_top;
  import swr_pkg::*;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [SEQ_W-1:0] seq_num;
  logic             is_finish;
  logic             out_valid;
  logic             out_ready;
  logic [SEQ_W-1:0] cumulative_ack;
  logic [SEQ_W-1:0] selective_ack;
  logic             store_payload;
  logic             finished;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] window_size;

  int               pending;
  int               errors;
  int               cycle_cnt = 0;
  int               ready_hold;
  int               ready_gap;
  bit               quiet;
  logic [SEQ_W-1:0] ack_seen;
  int unsigned      span;

  sliding_window_receiver_top #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .seq_num(seq_num),
    .is_finish(is_finish),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cumulative_ack(cumulative_ack),
    .selective_ack(selective_ack),
    .store_payload(store_payload),
    .finished(finished),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .window_size(window_size)
  );

  swr_scoreboard #(
    .WINDOW_DEPTH(DEPTH)
  ) chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .seq_num(seq_num),
    .is_finish(is_finish),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cumulative_ack(cumulative_ack),
    .selective_ack(selective_ack),
    .store_payload(store_payload),
    .finished(finished),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .window_size(window_size),
    .pending(pending),
    .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Latest cumulative ack seen, used to aim packets at the window
  always @(posedge clk) begin
    if (rst) ack_seen <= '0;
    else if (out_valid && out_ready) ack_seen <= cumulative_ack;
  end

  // Ack side: random stall after each transaction, none in quiet phases
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid && out_ready) begin
      ready_gap = quiet ? 0 : $urandom_range(0, 9);
      ready_hold <= ready_gap;
      out_ready <= (ready_gap == 0);
    end else if (!out_ready) begin
      if (ready_hold <= 1) out_ready <= 1'b1;
      if (ready_hold > 0) ready_hold <= ready_hold - 1;
    end
  end

  // One packet transaction, with an optional idle gap ahead of it
  task automatic send_packet(logic [SEQ_W-1:0] seq, logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_num <= seq;
    is_finish <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every owed ack has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_window(logic [CFG_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    span = (32'(w) > DEPTH) ? DEPTH : 32'(w);
  endtask

  initial begin
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] base;
    logic [CFG_W-1:0] w;
    int unsigned      near;
    int               kind;

    rst = 1'b1;
    in_valid = 1'b0;
    seq_num = '0;
    is_finish = 1'b0;
    cfg_valid = 1'b0;
    window_size = WINDOW_RESET;
    quiet = 1'b0;
    span = 32'(WINDOW_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: window at its reset size
    set_window(WINDOW_RESET);
    send_packet(32'hFFFF_FFFF, 1'b1);  // last number all ones: done already at zero
    send_packet(32'd0, 1'b0);          // in order, slides by one
    send_packet(32'd0, 1'b0);          // below the window now
    send_packet(32'd5, 1'b0);          // out of order, held
    send_packet(32'd5, 1'b0);          // duplicate
    send_packet(32'd200, 1'b0);        // last slot of the window
    send_packet(32'd201, 1'b1);        // just past the window, finish mark
    send_packet(32'd2, 1'b0);
    send_packet(32'd3, 1'b0);
    send_packet(32'd1, 1'b0);          // fills the first gap
    send_packet(32'd4, 1'b0);          // fills the second gap, slides past 5
    send_packet(32'd6, 1'b1);          // finish on the head packet
    send_packet(32'd10, 1'b1);         // repeated finish overrides
    send_packet(32'd8, 1'b0);
    send_packet(32'd9, 1'b0);
    send_packet(32'd7, 1'b0);          // slides through 10

    // Directed: one-slot, empty and oversized windows
    set_window(9'd1);
    drain();
    base = ack_seen;
    send_packet(base + 32'd1, 1'b0);
    send_packet(base, 1'b0);
    set_window(9'd0);
    send_packet(ack_seen, 1'b0);
    set_window(9'd511);
    drain();
    base = ack_seen;
    send_packet(base + 32'd255, 1'b0);
    send_packet(base + 32'd256, 1'b0);
    set_window(9'd256);
    send_packet(base + 32'd256, 1'b0);
    send_packet(base + 32'd255, 1'b0);

    // Random phases: mostly packets aimed at the window, the rest noise
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 8)
        0: w = 9'd1;
        1: w = 9'd256;
        2: w = 9'd511;
        3: w = 9'd0;
        4: w = CFG_W'($urandom_range(2, 255));
        5: w = CFG_W'($urandom_range(257, 511));
        6: w = 9'd2;
        default: w = CFG_W'($urandom_range(1, 511));
      endcase
      set_window(w);
      quiet <= ($urandom_range(0, 3) == 0);
      near = (span < 12) ? span : 12;
      for (int i = 0; i < 40; i++) begin
        kind = $urandom_range(0, 99);
        base = ack_seen;
        if (kind < 65) begin
          if (span == 0) seq = base;
          else if ($urandom_range(0, 3) != 0) seq = base + $urandom_range(0, near - 1);
          else seq = base + $urandom_range(0, span - 1);
        end else if (kind < 75) begin
          seq = base - $urandom_range(1, 16);
        end else if (kind < 85) begin
          seq = base + span + $urandom_range(0, 3);
        end else begin
          seq = $urandom;
        end
        send_packet(seq, $urandom_range(0, 14) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[sliding_window_receiver_top.f]
+incdir+hdl
hdl/swr_pkg.sv
hdl/swr_front.sv
hdl/swr_back.sv
hdl/sliding_window_receiver_top.sv
hdl/swr_checker.sv
test/swr_checker.sv
test/tb_top.sv
